### rtl/core/lc1d_pkg.sv
// ----------------------------------------------------------------------------
// lc1d_pkg
// Shared types and constants for the 1-D linear convolution unit.
// ----------------------------------------------------------------------------
package lc1d_pkg;

  localparam int MAX_TAPS_DEF = 32;
  localparam int DATA_W       = 32;
  localparam int KLEN_W       = 6;
  localparam int IDX_W        = 5;

  localparam logic ACT_COEF   = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

  localparam logic [KLEN_W-1:0] KLEN_RESET = KLEN_W'(1);

  typedef struct packed {
    logic                     action;
    logic [IDX_W-1:0]         tap_index;
    logic signed [DATA_W-1:0] sample;
    logic                     final_sample;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] result;
    logic                     last_result;
  } out_item_t;

  typedef struct packed {
    logic shift;
    logic tail;
    logic clear;
    logic prod_en;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROD,
    ST_ACC,
    ST_DONE
  } state_t;

endpackage

### rtl/core/lc1d_cell.sv
// ----------------------------------------------------------------------------
// lc1d_cell
// One tap of the chain: coefficient, delayed sample, product and partial sum.
// ----------------------------------------------------------------------------
module lc1d_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  lc1d_pkg::cell_ctrl_t          ctrl,
  input  logic                          enable,
  input  logic                          coef_we,
  input  logic [lc1d_pkg::DATA_W-1:0]   coef_data,
  input  logic [lc1d_pkg::DATA_W-1:0]   smp_in,
  input  logic [lc1d_pkg::DATA_W-1:0]   psum_in,
  output logic [lc1d_pkg::DATA_W-1:0]   smp_out,
  output logic [lc1d_pkg::DATA_W-1:0]   psum_out
);

  logic [lc1d_pkg::DATA_W-1:0] coeff;
  logic [lc1d_pkg::DATA_W-1:0] smp;
  logic [lc1d_pkg::DATA_W-1:0] prod;
  logic [lc1d_pkg::DATA_W-1:0] psum;
  logic [lc1d_pkg::DATA_W-1:0] mult;

  assign mult = coeff * smp;

  always_ff @(posedge clk) begin
    if (rst) begin
      coeff <= '0;
      smp   <= '0;
    end else begin
      if (coef_we) begin
        coeff <= coef_data;
      end
      if (ctrl.clear) begin
        smp <= '0;
      end else if (ctrl.shift) begin
        smp <= smp_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.prod_en) begin
      prod <= enable ? mult : '0;
    end
    psum <= psum_in + prod;
  end

  assign smp_out  = smp;
  assign psum_out = psum;

endmodule

### rtl/core/lc1d_ctrl.sv
// ----------------------------------------------------------------------------
// lc1d_ctrl
// Sequencer for the tap chain and output register.
// ----------------------------------------------------------------------------
module lc1d_ctrl #(
  parameter int MAX_TAPS = lc1d_pkg::MAX_TAPS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_action,
  input  logic                               in_final,
  input  logic [$clog2(MAX_TAPS+1)-1:0]      n_taps,
  input  logic [lc1d_pkg::DATA_W-1:0]        sum,
  output lc1d_pkg::cell_ctrl_t               cc,
  output logic                               coef_we,
  output logic                               out_valid,
  input  logic                               out_ready,
  output lc1d_pkg::out_item_t                out_item
);

  localparam int NW = $clog2(MAX_TAPS + 1);
  localparam int TW = $clog2(MAX_TAPS);

  lc1d_pkg::state_t state, state_next;
  logic [TW-1:0]    cnt, cnt_next;
  logic [TW-1:0]    tail_left, tail_left_next;
  logic             fin, fin_next;
  logic             out_load;
  logic             out_last;
  logic [TW-1:0]    n_m1;

  assign n_m1 = TW'(n_taps - NW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lc1d_pkg::ST_IDLE;
      cnt       <= '0;
      tail_left <= '0;
      fin       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      tail_left <= tail_left_next;
      fin       <= fin_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_item.result      <= sum;
      out_item.last_result <= out_last;
    end
  end

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    tail_left_next = tail_left;
    fin_next       = fin;
    in_ready       = 1'b0;
    coef_we        = 1'b0;
    cc             = '0;
    out_load       = 1'b0;
    out_last       = fin && (tail_left == '0);
    unique case (state)
      lc1d_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_action == lc1d_pkg::ACT_COEF) begin
            coef_we = 1'b1;
          end else begin
            cc.shift       = 1'b1;
            fin_next       = in_final;
            tail_left_next = in_final ? n_m1 : '0;
            state_next     = lc1d_pkg::ST_PROD;
          end
        end
      end
      lc1d_pkg::ST_PROD: begin
        cc.prod_en = 1'b1;
        cnt_next   = '0;
        state_next = lc1d_pkg::ST_ACC;
      end
      lc1d_pkg::ST_ACC: begin
        cnt_next = cnt + TW'(1);
        if (cnt == n_m1) begin
          state_next = lc1d_pkg::ST_DONE;
        end
      end
      lc1d_pkg::ST_DONE: begin
        if (!out_valid || out_ready) begin
          out_load = 1'b1;
          if (tail_left != '0) begin
            tail_left_next = tail_left - TW'(1);
            cc.shift       = 1'b1;
            cc.tail        = 1'b1;
            state_next     = lc1d_pkg::ST_PROD;
          end else begin
            cc.clear   = fin;
            state_next = lc1d_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_next = lc1d_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/core/linear_convolution_1d_unit.sv
// ----------------------------------------------------------------------------
// linear_convolution_1d_unit
// Streaming direct-form FIR giving the full linear convolution of a sample
// sequence with a stored kernel.
// ----------------------------------------------------------------------------
// A coefficient write is taken in the idle state. A sample is shifted into the
// tap chain, the per-tap products are registered, the partial sum ripples down
// the chain of adders, and the result is handed to the output register once it
// is free. A final sample adds n-1 tail results with zeros shifted in, where n
// is the number of taps in use, then clears the delay line. Results wait in an
// output register, so a new item is taken while the previous result is still
// pending.
// ----------------------------------------------------------------------------
module linear_convolution_1d_unit #(
  parameter int MAX_TAPS = lc1d_pkg::MAX_TAPS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  lc1d_pkg::in_item_t               in_item,
  output logic                             out_valid,
  input  logic                             out_ready,
  output lc1d_pkg::out_item_t              out_item,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [lc1d_pkg::KLEN_W-1:0]      cfg_data
);

  localparam int NW = $clog2(MAX_TAPS + 1);
  localparam int TW = $clog2(MAX_TAPS);
  localparam int CW = lc1d_pkg::KLEN_W + 1;
  localparam int DW = lc1d_pkg::DATA_W;

  logic [lc1d_pkg::KLEN_W-1:0] kernel_length;
  logic [NW-1:0]               n_taps;
  logic [CW-1:0]               klen_ext;
  lc1d_pkg::cell_ctrl_t        cc;
  logic                        coef_we;
  logic [DW-1:0]               front;
  logic [DW-1:0]               smp_chain  [MAX_TAPS];
  logic [DW-1:0]               psum_chain [MAX_TAPS];
  logic [DW-1:0]               sum;
  logic [TW-1:0]               sel;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_length <= lc1d_pkg::KLEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      kernel_length <= cfg_data;
    end
  end

  // zero counts as one tap, oversize saturates
  assign klen_ext = CW'(kernel_length);
  always_comb begin
    if (kernel_length == '0) begin
      n_taps = NW'(1);
    end else if (klen_ext > CW'(MAX_TAPS)) begin
      n_taps = NW'(MAX_TAPS);
    end else begin
      n_taps = NW'(klen_ext);
    end
  end

  assign front = cc.tail ? '0 : in_item.sample;

  for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
    logic en;
    logic we;
    assign en = NW'(k) < n_taps;
    assign we = coef_we && (CW'(in_item.tap_index) == CW'(k));
    lc1d_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (cc),
      .enable    (en),
      .coef_we   (we),
      .coef_data (in_item.sample),
      .smp_in    ((k == 0) ? front : smp_chain[(k == 0) ? 0 : k-1]),
      .psum_in   ((k == 0) ? '0 : psum_chain[(k == 0) ? 0 : k-1]),
      .smp_out   (smp_chain[k]),
      .psum_out  (psum_chain[k])
    );
  end

  assign sel = TW'(n_taps - NW'(1));
  assign sum = psum_chain[sel];

  lc1d_ctrl #(
    .MAX_TAPS (MAX_TAPS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_action (in_item.action),
    .in_final  (in_item.final_sample),
    .n_taps    (n_taps),
    .sum       (sum),
    .cc        (cc),
    .coef_we   (coef_we),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

### tb/sv/lc1d_checker.sv
// ----------------------------------------------------------------------------
// lc1d_checker
// Watches the sample, result and kernel length channels of the convolution
// unit. Keeps its own kernel, delay line and tap count, works out the
// results each accepted item must give, and compares every accepted result
// in order against them. Hands the failure count to the testbench top.
// ----------------------------------------------------------------------------
module lc1d_checker #(
  parameter int MAX_TAPS = lc1d_pkg::MAX_TAPS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  lc1d_pkg::in_item_t          in_item,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  lc1d_pkg::out_item_t         out_item,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [lc1d_pkg::KLEN_W-1:0] cfg_data,
  output int                          fail_count,
  output int                          results_seen,
  output int                          outstanding
);

  logic [lc1d_pkg::DATA_W-1:0] coef_mem [MAX_TAPS];
  logic [lc1d_pkg::DATA_W-1:0] delay_line [MAX_TAPS-1];
  logic [lc1d_pkg::KLEN_W-1:0] tap_count;
  lc1d_pkg::out_item_t         conv_expected_q [$];

  initial begin
    fail_count   = 0;
    results_seen = 0;
    outstanding  = 0;
  end

  function automatic int taps_in_use();
    if (tap_count == 0) return 1;
    if (int'(tap_count) > MAX_TAPS) return MAX_TAPS;
    return int'(tap_count);
  endfunction

  function automatic logic [lc1d_pkg::DATA_W-1:0] window_sum(
    logic [lc1d_pkg::DATA_W-1:0] front,
    int                          n
  );
    logic [lc1d_pkg::DATA_W-1:0] acc;
    acc = coef_mem[0] * front;
    for (int k = 1; k < n; k++) acc = acc + coef_mem[k] * delay_line[k-1];
    return acc;
  endfunction

  function automatic void shift_delay(logic [lc1d_pkg::DATA_W-1:0] v);
    for (int j = MAX_TAPS - 2; j > 0; j--) delay_line[j] = delay_line[j-1];
    delay_line[0] = v;
  endfunction

  function automatic void clear_state();
    foreach (coef_mem[i]) coef_mem[i] = '0;
    foreach (delay_line[i]) delay_line[i] = '0;
    tap_count = lc1d_pkg::KLEN_RESET;
  endfunction

  function automatic void predict_conv(lc1d_pkg::in_item_t it);
    lc1d_pkg::out_item_t exp_item;
    int                  n;
    if (it.action == lc1d_pkg::ACT_COEF) begin
      if (int'(it.tap_index) < MAX_TAPS) coef_mem[it.tap_index] = it.sample;
      return;
    end
    n = taps_in_use();
    exp_item.result      = window_sum(it.sample, n);
    exp_item.last_result = it.final_sample && (n == 1);
    conv_expected_q.push_back(exp_item);
    shift_delay(it.sample);
    if (it.final_sample) begin
      for (int t = 1; t < n; t++) begin
        exp_item.result      = window_sum('0, n);
        exp_item.last_result = (t == n - 1);
        conv_expected_q.push_back(exp_item);
        shift_delay('0);
      end
      foreach (delay_line[i]) delay_line[i] = '0;
    end
  endfunction

  function automatic void flag(string msg);
    fail_count++;
    $error("%s", msg);
  endfunction

  always @(posedge clk) begin
    lc1d_pkg::out_item_t want;
    if (rst) begin
      clear_state();
      conv_expected_q.delete();
      outstanding <= 0;
    end else begin
      if (cfg_valid && cfg_ready) tap_count = cfg_data;
      if (in_valid && in_ready) predict_conv(in_item);
      if (out_valid && out_ready) begin
        results_seen++;
        if (conv_expected_q.size() == 0) begin
          flag($sformatf("unexpected result %0d, last_result %0b, none pending",
                         out_item.result, out_item.last_result));
        end else begin
          want = conv_expected_q.pop_front();
          if (out_item.result !== want.result)
            flag($sformatf("result mismatch: expected %0d, actual %0d",
                           want.result, out_item.result));
          if (out_item.last_result !== want.last_result)
            flag($sformatf("last_result mismatch: expected %0b, actual %0b",
                           want.last_result, out_item.last_result));
        end
      end
      outstanding <= conv_expected_q.size();
    end
  end

endmodule

### tb/sv/tb_linear_convolution_1d_unit.sv
// ----------------------------------------------------------------------------
// tb_linear_convolution_1d_unit
// Regression for the 1-D linear convolution unit. A directed opening covers
// extreme values, single-tap and saturated kernel lengths, zero length and
// length changes inside a sequence; random sequences of coefficient loads
// and samples follow, with random stalls on both channels. Checking is done
// by lc1d_checker beside the block.
// ----------------------------------------------------------------------------
module tb_linear_convolution_1d_unit;

  localparam int TARGET_ITEMS = 500;
  localparam int QUIET_ITEMS  = 60;
  localparam int SETTLE       = 40;

  localparam int DATA_W = lc1d_pkg::DATA_W;
  localparam int KLEN_W = lc1d_pkg::KLEN_W;
  localparam int IDX_W  = lc1d_pkg::IDX_W;
  localparam int TAPS   = lc1d_pkg::MAX_TAPS_DEF;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  lc1d_pkg::in_item_t  in_item = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  lc1d_pkg::out_item_t out_item;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [KLEN_W-1:0]   cfg_data = '0;

  int fail_count;
  int results_seen;
  int outstanding;

  logic stall_on = 1'b1;
  logic no_idle  = 1'b0;
  int   stall_left = 0;
  int   items_sent = 0;
  int   length_writes = 0;
  bit   gaps_on = 1'b1;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  linear_convolution_1d_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  lc1d_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_item      (in_item),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_item     (out_item),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .results_seen (results_seen),
    .outstanding  (outstanding)
  );

  // result side back-pressure in bursts
  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stall_on && !no_idle && $urandom_range(0, 7) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 15);
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic lc1d_pkg::in_item_t coef_item(
    logic [IDX_W-1:0]  idx,
    logic [DATA_W-1:0] val
  );
    lc1d_pkg::in_item_t it;
    it.action       = lc1d_pkg::ACT_COEF;
    it.tap_index    = idx;
    it.sample       = val;
    it.final_sample = 1'b0;
    return it;
  endfunction

  function automatic lc1d_pkg::in_item_t sample_item(
    logic [DATA_W-1:0] val,
    logic              fin
  );
    lc1d_pkg::in_item_t it;
    it.action       = lc1d_pkg::ACT_SAMPLE;
    it.tap_index    = IDX_W'($urandom);
    it.sample       = val;
    it.final_sample = fin;
    return it;
  endfunction

  function automatic logic [DATA_W-1:0] pick_word();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return DATA_W'(1);
      2:       return '1;
      3:       return {1'b0, {(DATA_W-1){1'b1}}};
      4:       return {1'b1, {(DATA_W-1){1'b0}}};
      5:       return DATA_W'($urandom_range(0, 15)) - DATA_W'(8);
      default: return DATA_W'($urandom);
    endcase
  endfunction

  function automatic logic [KLEN_W-1:0] pick_length();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return KLEN_W'(TAPS);
      2:       return KLEN_W'(TAPS + 1);
      3:       return '1;
      4, 5:    return KLEN_W'($urandom_range(9, TAPS - 1));
      default: return KLEN_W'($urandom_range(1, 8));
    endcase
  endfunction

  task automatic drive_item(lc1d_pkg::in_item_t it);
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic hold_sender(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic random_gap();
    if (gaps_on && !no_idle && $urandom_range(0, 3) == 0)
      hold_sender($urandom_range(1, 16));
  endtask

  // sender drops valid and waits for every pending result to be taken
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_length(logic [KLEN_W-1:0] len);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= len;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    length_writes++;
  endtask

  task automatic random_sequence();
    int nsamp;
    bit open_end;
    repeat ($urandom_range(0, 6)) begin
      random_gap();
      drive_item(coef_item(IDX_W'($urandom), pick_word()));
    end
    nsamp    = $urandom_range(1, 12);
    open_end = ($urandom_range(0, 7) == 0);
    for (int i = 0; i < nsamp; i++) begin
      random_gap();
      if ($urandom_range(0, 9) == 0)
        drive_item(coef_item(IDX_W'($urandom), pick_word()));
      if (i == nsamp - 1)
        drive_item(sample_item(pick_word(), !open_end));
      else
        drive_item(sample_item(pick_word(), $urandom_range(0, 19) == 0));
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // single tap at reset length, extremes
    drive_item(coef_item(5'd0, 32'h7fff_ffff));
    drive_item(sample_item(32'h8000_0000, 1'b1));
    write_length('0);
    drive_item(sample_item(32'hffff_ffff, 1'b0));
    drive_item(sample_item(32'h0000_0001, 1'b1));
    // saturated length, all 32 taps with long tail
    write_length('1);
    drive_item(coef_item(5'd31, 32'hffff_ffff));
    drive_item(coef_item(5'd0, 32'h8000_0000));
    drive_item(coef_item(5'd16, 32'h1234_5678));
    drive_item(sample_item(32'h7fff_ffff, 1'b0));
    drive_item(sample_item(32'h8000_0000, 1'b1));
    write_length(KLEN_W'(TAPS));
    drive_item(sample_item(32'hffff_ffff, 1'b1));
    // length change inside an open sequence
    write_length(KLEN_W'(3));
    drive_item(coef_item(5'd1, 32'd5));
    drive_item(coef_item(5'd2, 32'hffff_fffd));
    drive_item(sample_item(32'd10, 1'b0));
    drive_item(sample_item(32'hffff_fff9, 1'b0));
    write_length(KLEN_W'(5));
    drive_item(coef_item(5'd4, 32'h5555_5555));
    drive_item(sample_item(32'h2aaa_aaaa, 1'b0));
    drive_item(sample_item(32'h0, 1'b1));
    write_length(KLEN_W'(TAPS + 1));
    drive_item(sample_item(32'h1, 1'b1));
    write_length(KLEN_W'(1));
    drive_item(sample_item(32'h0, 1'b0));
    drive_item(coef_item(5'd0, 32'h0));
    drive_item(sample_item(32'hffff_ffff, 1'b1));

    while (items_sent < TARGET_ITEMS) begin
      if (items_sent >= TARGET_ITEMS - QUIET_ITEMS) no_idle <= 1'b1;
      if ($urandom_range(0, 2) != 0) write_length(pick_length());
      gaps_on = ($urandom_range(0, 3) != 0);
      stall_on <= ($urandom_range(0, 3) != 0);
      random_sequence();
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE) @(posedge clk);

    $display("%0d items sent across %0d kernel length writes, %0d results compared",
             items_sent, length_writes, results_seen);
    if (fail_count == 0) begin
      $display("linear_convolution_1d_unit regression: pass");
    end else begin
      $display("linear_convolution_1d_unit regression: fail");
    end
    $finish;
  end

  initial begin
    #80_000_000;
    $display("linear_convolution_1d_unit regression: fail");
    $finish;
  end

endmodule
